### rtl/elg_pkg.sv
package elg_pkg;

    localparam int MOD_BITS = 16;
    localparam int EXP_BITS = 32;
    localparam int REG_BITS = 16;
    localparam int BYTE_BITS = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int EXP_CNT_BITS = $clog2(EXP_BITS);
    localparam int MUL_CNT_BITS = $clog2(MOD_BITS + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GENERATOR = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY       = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_EXP = 2'd3;

endpackage

### rtl/elgamal_byte_encryptor.sv
// each exponentiation is 33+k serial multiplies, k = set bits in the exponent; both run side
// by side, then one more multiply by the byte; a modulus below 2 skips them all and gives a
// zero result
// throughput: one byte at a time, the next taken the cycle after the result transfer
// reset: asynchronous active low; modulus 2, generator 1, key 1, start exponent 1, exponent 0
module elgamal_byte_encryptor
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [elg_pkg::BYTE_BITS-1:0]         s_axis_tdata,   // message_byte
    input  logic                                  s_axis_tuser,   // first_of_text
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [2*elg_pkg::MOD_BITS-1:0]        m_axis_tdata,   // cipher_a, cipher_b
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [elg_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [elg_pkg::REG_BITS-1:0]          cfg_data
);

    localparam int W = elg_pkg::MOD_BITS;

    typedef enum logic [3:0]
    {
        TOP_IDLE = 4'b0001,
        TOP_EXP  = 4'b0010,
        TOP_BYTE = 4'b0100,
        TOP_OUT  = 4'b1000
    } top_state_t;

    top_state_t                     state_reg;
    logic [W-1:0]                   modulus_reg;
    logic [W-1:0]                   generator_reg;
    logic [W-1:0]                   key_reg;
    logic [elg_pkg::REG_BITS-1:0]   start_exp_reg;
    logic [elg_pkg::EXP_BITS-1:0]   exp_reg;
    logic [elg_pkg::EXP_BITS-1:0]   exp_next;
    logic [elg_pkg::BYTE_BITS-1:0]  byte_reg;
    logic [W-1:0]                   a_reg;
    logic                           a_done_reg;
    logic                           k_done_reg;
    logic                           exp_go;
    logic                           ea_done;
    logic                           ek_done;
    logic [W-1:0]                   ea_res;
    logic [W-1:0]                   ek_res;
    logic                           bm_go_reg;
    logic                           bm_done;
    logic [W-1:0]                   bm_res;
    logic [W-1:0]                   a_out_reg;
    logic [W-1:0]                   b_out_reg;
    logic                           field_ok;
    logic                           in_xfer;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == TOP_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign field_ok      = (modulus_reg >= W'(2));
    assign exp_next      = s_axis_tuser ? elg_pkg::EXP_BITS'(start_exp_reg) : exp_reg + 1'b1;
    assign exp_go        = in_xfer && field_ok;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= W'(2);
            generator_reg <= W'(1);
            key_reg       <= W'(1);
            start_exp_reg <= elg_pkg::REG_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                elg_pkg::CFG_MODULUS:   modulus_reg   <= W'(cfg_data);
                elg_pkg::CFG_GENERATOR: generator_reg <= W'(cfg_data);
                elg_pkg::CFG_KEY:       key_reg       <= W'(cfg_data);
                elg_pkg::CFG_START_EXP: start_exp_reg <= cfg_data;
                default:                start_exp_reg <= start_exp_reg;
            endcase
        end
    end

    elg_modexp u_exp_a
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (exp_go),
        .base   (generator_reg),
        .expo   (exp_next),
        .m      (modulus_reg),
        .done   (ea_done),
        .result (ea_res)
    );

    elg_modexp u_exp_k
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (exp_go),
        .base   (key_reg),
        .expo   (exp_next),
        .m      (modulus_reg),
        .done   (ek_done),
        .result (ek_res)
    );

    // byte times key power: the power is below m, the byte is the serial operand
    elg_modmul u_byte_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bm_go_reg),
        .x      (ek_res),
        .y      (W'(byte_reg)),
        .m      (modulus_reg),
        .done   (bm_done),
        .result (bm_res)
    );

    // sequencer and exponent register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= TOP_IDLE;
            exp_reg    <= '0;
            a_done_reg <= 1'b0;
            k_done_reg <= 1'b0;
            bm_go_reg  <= 1'b0;
        end
        else
        begin
            bm_go_reg <= 1'b0;
            case (state_reg)
                TOP_IDLE:
                begin
                    if (in_xfer)
                    begin
                        exp_reg    <= exp_next;
                        a_done_reg <= 1'b0;
                        k_done_reg <= 1'b0;
                        state_reg  <= field_ok ? TOP_EXP : TOP_OUT;
                    end
                end
                TOP_EXP:
                begin
                    if (ea_done)
                    begin
                        a_done_reg <= 1'b1;
                    end
                    if (ek_done)
                    begin
                        k_done_reg <= 1'b1;
                    end
                    if ((a_done_reg || ea_done) && (k_done_reg || ek_done))
                    begin
                        state_reg <= TOP_BYTE;
                        bm_go_reg <= 1'b1;
                    end
                end
                TOP_BYTE:
                begin
                    if (bm_done)
                    begin
                        state_reg <= TOP_OUT;
                    end
                end
                TOP_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= TOP_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= TOP_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg  <= s_axis_tdata;
            a_out_reg <= '0;
            b_out_reg <= '0;
        end
        if (state_reg == TOP_EXP && ea_done)
        begin
            a_reg <= ea_res;
        end
        if (state_reg == TOP_BYTE && bm_done)
        begin
            a_out_reg <= a_reg;
            b_out_reg <= bm_res;
        end
    end

    assign m_axis_tvalid = (state_reg == TOP_OUT);
    assign m_axis_tdata  = {b_out_reg, a_out_reg};

endmodule

### rtl/elg_modmul.sv
// bit-serial modular multiplier: one multiplier bit per cycle, msb first
// result = x * y mod m, with x < m, m >= 2; y may be any MOD_BITS value
module elg_modmul
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [elg_pkg::MOD_BITS-1:0] x,
    input  logic [elg_pkg::MOD_BITS-1:0] y,
    input  logic [elg_pkg::MOD_BITS-1:0] m,
    output logic                         done,
    output logic [elg_pkg::MOD_BITS-1:0] result
);

    localparam int W = elg_pkg::MOD_BITS;

    logic                               busy_reg;
    logic [elg_pkg::MUL_CNT_BITS-1:0]   cnt_reg;
    logic [W-1:0]                       y_reg;
    logic [W-1:0]                       acc_reg;
    logic                               done_reg;
    logic [W+1:0]                       dbl;
    logic [W+1:0]                       dbl_red;
    logic [W+1:0]                       add;
    logic [W-1:0]                       acc_next;

    // acc = 2*acc mod m, then + x if the bit is set, each with one compare and subtract
    always_comb
    begin
        dbl = {1'b0, acc_reg, 1'b0};
        dbl_red = (dbl >= {2'b00, m}) ? dbl - {2'b00, m} : dbl;
        add = dbl_red + (y_reg[W-1] ? {2'b00, x} : '0);
        acc_next = (add >= {2'b00, m}) ? W'(add - {2'b00, m}) : add[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == elg_pkg::MUL_CNT_BITS'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            y_reg   <= y;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            y_reg   <= {y_reg[W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

### rtl/elg_modexp.sv
// square-and-multiply exponentiation, exponent shifted out msb first
// base is reduced by a multiply by one first
module elg_modexp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [elg_pkg::MOD_BITS-1:0] base,
    input  logic [elg_pkg::EXP_BITS-1:0] expo,
    input  logic [elg_pkg::MOD_BITS-1:0] m,
    output logic                         done,
    output logic [elg_pkg::MOD_BITS-1:0] result
);

    localparam int W = elg_pkg::MOD_BITS;

    typedef enum logic [4:0]
    {
        ST_IDLE = 5'b00001,
        ST_RED  = 5'b00010,
        ST_SQR  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } exp_state_t;

    exp_state_t                         state_reg;
    logic [elg_pkg::EXP_BITS-1:0]       e_reg;
    logic [elg_pkg::EXP_CNT_BITS-1:0]   bit_reg;
    logic [W-1:0]                       b_reg;
    logic [W-1:0]                       acc_reg;
    logic                               mm_start;
    logic [W-1:0]                       mm_x;
    logic [W-1:0]                       mm_y;
    logic                               mm_done;
    logic [W-1:0]                       mm_res;
    logic                               mm_go_reg;

    elg_modmul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .x      (mm_x),
        .y      (mm_y),
        .m      (m),
        .done   (mm_done),
        .result (mm_res)
    );

    // operand selection per phase; reduction computes 1 * base
    always_comb
    begin
        case (state_reg)
            ST_RED:
            begin
                mm_x = W'(1);
                mm_y = base;
            end
            ST_SQR:
            begin
                mm_x = acc_reg;
                mm_y = acc_reg;
            end
            ST_MUL:
            begin
                mm_x = b_reg;
                mm_y = acc_reg;
            end
            default:
            begin
                mm_x = '0;
                mm_y = '0;
            end
        endcase
    end

    assign mm_start = mm_go_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mm_go_reg <= 1'b0;
            bit_reg   <= '0;
        end
        else
        begin
            mm_go_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_RED;
                        mm_go_reg <= 1'b1;
                        bit_reg   <= '0;
                    end
                end
                ST_RED:
                begin
                    if (mm_done)
                    begin
                        state_reg <= ST_SQR;
                        mm_go_reg <= 1'b1;
                    end
                end
                ST_SQR:
                begin
                    if (mm_done)
                    begin
                        if (e_reg[elg_pkg::EXP_BITS-1])
                        begin
                            state_reg <= ST_MUL;
                            mm_go_reg <= 1'b1;
                        end
                        else if (bit_reg == elg_pkg::EXP_CNT_BITS'(elg_pkg::EXP_BITS - 1))
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            bit_reg   <= bit_reg + 1'b1;
                            mm_go_reg <= 1'b1;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (mm_done)
                    begin
                        if (bit_reg == elg_pkg::EXP_CNT_BITS'(elg_pkg::EXP_BITS - 1))
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_SQR;
                            bit_reg   <= bit_reg + 1'b1;
                            mm_go_reg <= 1'b1;
                        end
                    end
                end
                ST_DONE:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // exponent shift register and accumulator
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            e_reg   <= expo;
            acc_reg <= W'(1);
        end
        else if (mm_done)
        begin
            case (state_reg)
                ST_RED:
                begin
                    b_reg <= mm_res;
                end
                ST_SQR:
                begin
                    acc_reg <= mm_res;
                    if (!e_reg[elg_pkg::EXP_BITS-1])
                    begin
                        e_reg <= {e_reg[elg_pkg::EXP_BITS-2:0], 1'b0};
                    end
                end
                ST_MUL:
                begin
                    acc_reg <= mm_res;
                    e_reg   <= {e_reg[elg_pkg::EXP_BITS-2:0], 1'b0};
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign done   = (state_reg == ST_DONE);
    assign result = acc_reg;

endmodule

### tb/elgamal_byte_encryptor_test.sv
`timescale 1ns / 100ps

module elgamal_byte_encryptor_test;

    localparam int CLK_HALF = 6;
    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_CYCLES = 1500;
    localparam int RANDOM_BYTES = 1525;

    typedef struct packed {
        logic [elg_pkg::MOD_BITS-1:0] a;
        logic [elg_pkg::MOD_BITS-1:0] b;
    } cipher_pair_t;

    // one directed row: config change (optional), byte, start flag, known result
    typedef struct {
        bit                                do_cfg;
        logic [elg_pkg::CFG_IDX_BITS-1:0]  idx;
        logic [elg_pkg::REG_BITS-1:0]      val;
        logic [elg_pkg::BYTE_BITS-1:0]     msg;
        bit                                first;
        bit                                known;
        cipher_pair_t                      want;
    } byte_row_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  s_axis_tvalid;
    logic                                  s_axis_tready;
    logic [elg_pkg::BYTE_BITS-1:0]         s_axis_tdata;
    logic                                  s_axis_tuser;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready;
    logic [2*elg_pkg::MOD_BITS-1:0]        m_axis_tdata;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [elg_pkg::CFG_IDX_BITS-1:0]      cfg_index;
    logic [elg_pkg::REG_BITS-1:0]          cfg_data;

    // predictor state
    logic [elg_pkg::REG_BITS-1:0] p_mod, p_gen, p_key, p_start;
    logic [elg_pkg::EXP_BITS-1:0] p_exp;

    cipher_pair_t pending_ciphers[$];
    int  mismatches;
    bit  failed;
    int  idle_cycles;
    bit  hold_random;

    elgamal_byte_encryptor dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // modular power, top bit first
    function automatic logic [63:0] pow_mod(logic [63:0] base,
                                            logic [elg_pkg::EXP_BITS-1:0] e,
                                            logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] bm;
        acc = 1 % m;
        bm = base % m;
        for (int i = elg_pkg::EXP_BITS - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % m;
            if (e[i])
                acc = (acc * bm) % m;
        end
        return acc;
    endfunction

    function automatic cipher_pair_t encrypt_byte(logic [elg_pkg::BYTE_BITS-1:0] msg,
                                                  bit first);
        cipher_pair_t r;
        logic [63:0] kp;
        p_exp = first ? elg_pkg::EXP_BITS'(p_start) : p_exp + 1'b1;
        r = '0;
        if (p_mod >= 2)
        begin
            r.a = elg_pkg::MOD_BITS'(pow_mod(64'(p_gen), p_exp, 64'(p_mod)));
            kp = pow_mod(64'(p_key), p_exp, 64'(p_mod));
            r.b = elg_pkg::MOD_BITS'((64'(msg) * kp) % 64'(p_mod));
        end
        return r;
    endfunction

    task automatic note_mismatch(cipher_pair_t want, cipher_pair_t got, string what);
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected a=%h b=%h, got a=%h b=%h", what, want.a, want.b,
                     got.a, got.b);
    endtask

    // gaps: mostly short, now and then long
    function automatic int gap_len();
        if (hold_random)
            return 0;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return 0;
            19: return $urandom_range(20, 300);
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    // result side: random stall, check against oldest expectation
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = gap_len();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            if (pending_ciphers.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected cipher pair %h", m_axis_tdata);
            end
            else
            begin
                cipher_pair_t want;
                cipher_pair_t got;
                want = pending_ciphers.pop_front();
                got.a = m_axis_tdata[elg_pkg::MOD_BITS-1:0];
                got.b = m_axis_tdata[2*elg_pkg::MOD_BITS-1:elg_pkg::MOD_BITS];
                if (got.a !== want.a || got.b !== want.b)
                    note_mismatch(want, got, "cipher pair");
            end
        end
    end

    // watchdog on transfer activity
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(logic [elg_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [elg_pkg::REG_BITS-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            elg_pkg::CFG_MODULUS:   p_mod = val;
            elg_pkg::CFG_GENERATOR: p_gen = val;
            elg_pkg::CFG_KEY:       p_key = val;
            elg_pkg::CFG_START_EXP: p_start = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_byte(logic [elg_pkg::BYTE_BITS-1:0] msg, bit first, bit known,
                             cipher_pair_t want);
        cipher_pair_t pred;
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= msg;
        s_axis_tuser <= first;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = encrypt_byte(msg, first);
        if (known && pred !== want)
            note_mismatch(want, pred, "predictor row");
        pending_ciphers.insert(pending_ciphers.size(), known ? want : pred);
    endtask

    // wait till idle so registers may change
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_ciphers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_setting();
        logic [elg_pkg::REG_BITS-1:0] m;
        case ($urandom_range(0, 9))
            0: m = 16'hffff;
            1: m = 16'd1;
            2: m = 16'd0;
            3: m = 16'hfff1;
            4: m = elg_pkg::REG_BITS'($urandom_range(2, 300));
            default: m = elg_pkg::REG_BITS'($urandom_range(2, 16'hffff));
        endcase
        write_reg(elg_pkg::CFG_MODULUS, m);
        write_reg(elg_pkg::CFG_GENERATOR,
                  ($urandom_range(0, 7) == 0) ? 16'hffff : elg_pkg::REG_BITS'($urandom()));
        write_reg(elg_pkg::CFG_KEY,
                  ($urandom_range(0, 7) == 0) ? 16'h0000 : elg_pkg::REG_BITS'($urandom()));
        write_reg(elg_pkg::CFG_START_EXP,
                  ($urandom_range(0, 7) == 0) ? 16'hffff : elg_pkg::REG_BITS'($urandom()));
    endtask

    byte_row_t rows[];

    initial
    begin
        int sent;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        failed = 1'b0;
        idle_cycles = 0;
        hold_random = 1'b0;
        p_mod = 16'd2;
        p_gen = 16'd1;
        p_key = 16'd1;
        p_start = 16'd1;
        p_exp = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            // byte without a start after reset, modulus 2: a=1, b=byte mod 2
            '{0, elg_pkg::CFG_MODULUS, 0, 8'hff, 0, 1, '{16'd1, 16'd1}},
            '{0, elg_pkg::CFG_MODULUS, 0, 8'h00, 1, 1, '{16'd1, 16'd0}},
            '{1, elg_pkg::CFG_MODULUS, 16'hffff, 8'h01, 1, 0, '{0, 0}},
            '{1, elg_pkg::CFG_GENERATOR, 16'hffff, 8'hff, 0, 0, '{0, 0}},
            '{1, elg_pkg::CFG_KEY, 16'hfffe, 8'h80, 0, 0, '{0, 0}},
            // start exponent zero gives a=1, b=byte
            '{1, elg_pkg::CFG_START_EXP, 16'd0, 8'hab, 1, 1, '{16'd1, 16'h00ab}},
            '{0, elg_pkg::CFG_MODULUS, 0, 8'h55, 0, 0, '{0, 0}},
            '{1, elg_pkg::CFG_START_EXP, 16'hffff, 8'hff, 1, 0, '{0, 0}},
            '{0, elg_pkg::CFG_MODULUS, 0, 8'h7f, 0, 0, '{0, 0}},
            // bases above the modulus, then a zero generator
            '{1, elg_pkg::CFG_MODULUS, 16'd251, 8'hff, 1, 0, '{0, 0}},
            '{1, elg_pkg::CFG_GENERATOR, 16'd0, 8'h10, 0, 0, '{0, 0}},
            // modulus one and zero: everything zero
            '{1, elg_pkg::CFG_MODULUS, 16'd1, 8'hff, 1, 1, '{16'd0, 16'd0}},
            '{0, elg_pkg::CFG_MODULUS, 0, 8'h01, 0, 1, '{16'd0, 16'd0}},
            '{1, elg_pkg::CFG_MODULUS, 16'd0, 8'hff, 1, 1, '{16'd0, 16'd0}},
            '{1, elg_pkg::CFG_START_EXP, 16'd0, 8'h33, 1, 1, '{16'd0, 16'd0}},
            '{1, elg_pkg::CFG_MODULUS, 16'hfff1, 8'hc3, 1, 0, '{0, 0}},
            '{1, elg_pkg::CFG_KEY, 16'd0, 8'h3c, 0, 0, '{0, 0}}
        };
        foreach (rows[i])
        begin
            if (rows[i].do_cfg)
            begin
                drain();
                write_reg(rows[i].idx, rows[i].val);
            end
            send_byte(rows[i].msg, rows[i].first, rows[i].known, rows[i].want);
        end

        // exponent wrap: drive the register to all ones by hand is too slow, so
        // start at 0xffff and run on; wraps are covered by the predictor width
        drain();
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            int run_len;
            if ($urandom_range(0, 7) == 0)
            begin
                drain();
                random_setting();
            end
            hold_random = ($urandom_range(0, 5) == 0);
            run_len = $urandom_range(1, 20);
            for (int k = 0; k < run_len && sent < RANDOM_BYTES; k++)
            begin
                send_byte(elg_pkg::BYTE_BITS'($urandom_range(0, 255)),
                          (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 15) == 0),
                          0, '{0, 0});
                sent++;
            end
            hold_random = 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        while (pending_ciphers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (!failed && pending_ciphers.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
rtl/elg_pkg.sv
rtl/elg_modmul.sv
rtl/elg_modexp.sv
rtl/elgamal_byte_encryptor.sv
tb/elgamal_byte_encryptor_test.sv
